FILE: hw/rtl/stirt_pkg.sv
// shared types, constants and helpers for the signed integer to radix text block
// no dependencies; used by stirt_ctrl, stirt_dp and signed_integer_to_radix_text
package stirt_pkg;

   // fixed field widths
   localparam int SIZE_W     = 5;
   localparam int SYMBOL_W   = 8;
   localparam int DIGIT_W    = 4;
   localparam int CSR_DATA_W = 64;
   localparam int CSR_IDX_W  = 2;
   localparam int SLOTS      = 16;

   // default for the top-level parameter
   localparam int VALUE_BITS_DEFAULT = 32;

   // largest radix the alphabet may define
   localparam int MAX_SYMBOLS = 16;

   // special characters
   localparam logic [SYMBOL_W-1:0] PLUS_CHAR  = 8'h2B;
   localparam logic [SYMBOL_W-1:0] MINUS_CHAR = 8'h2D;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_ALPHABET_SIZE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_SYMBOLS_LOW   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_SYMBOLS_HIGH  = 2'd2;

   // register reset values: ten symbols "1234567889"; the repeated '8' fails the alphabet check
   localparam logic [SIZE_W-1:0]     ALPHABET_SIZE_RESET = 5'd10;
   localparam logic [CSR_DATA_W-1:0] SYMBOLS_LOW_RESET   = 64'd4050765991979987505;
   localparam logic [CSR_DATA_W-1:0] SYMBOLS_HIGH_RESET  = 64'd14648;

   typedef struct packed {
      logic [SIZE_W-1:0]     alphabet_size;
      logic [CSR_DATA_W-1:0] symbols_low;
      logic [CSR_DATA_W-1:0] symbols_high;
   } cfg_type;

   // controller to datapath
   typedef struct packed {
      logic start;
      logic div_step;
      logic mem_read;
      logic rd_dec;
      logic load_sign;
      logic load_digit;
      logic load_invalid;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic alpha_ok;
      logic negative;
      logic div_last;
      logic quot_zero;
      logic rd_zero;
   } sts_type;

   // pick one byte symbol out of the alphabet
   function automatic logic [SYMBOL_W-1:0] symbol_at(input logic [CSR_DATA_W-1:0] lo,
                                                     input logic [CSR_DATA_W-1:0] hi,
                                                     input logic [DIGIT_W-1:0]    idx);
      logic [2*CSR_DATA_W-1:0] w;
      w = {hi, lo};
      return w[{idx, 3'b000} +: SYMBOL_W];
   endfunction

endpackage

FILE: hw/rtl/signed_integer_to_radix_text.sv
// top level: configuration registers, controller and datapath
// depends on stirt_pkg, stirt_ctrl and stirt_dp
//
// channel   direction  handshake              payload
// req_      in         req_valid/req_ready    req_value (VALUE_BITS, signed)
// rsp_      out        rsp_valid/rsp_ready    rsp_symbol, rsp_last, rsp_invalid
// csr_      in         csr_valid/csr_ready    csr_index, csr_data
//
// one item at a time: accept, an alphabet check, a minus sign for a negative
// value, then the bit-serial divider produces every digit into the digit
// memory, and each digit is read back from it and emitted in turn.
// an invalid alphabet gives a single invalid result instead.
// reset is synchronous, active high.
// a stalled result holds the output register and pauses the emission loop.
module signed_integer_to_radix_text #(
   parameter int VALUE_BITS = stirt_pkg::VALUE_BITS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic signed [VALUE_BITS-1:0]        req_value,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [stirt_pkg::SYMBOL_W-1:0]      rsp_symbol,
   output logic                                rsp_last,
   output logic                                rsp_invalid,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [stirt_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [stirt_pkg::CSR_DATA_W-1:0]    csr_data
);

   stirt_pkg::cfg_type cfg_ff, cfg_in;
   stirt_pkg::cmd_type cmd;
   stirt_pkg::sts_type sts;
   logic               csr_write;

   // configuration writes are always taken
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_index)
            stirt_pkg::REG_ALPHABET_SIZE: begin
               cfg_in.alphabet_size = csr_data[stirt_pkg::SIZE_W-1:0];
            end
            stirt_pkg::REG_SYMBOLS_LOW: begin
               cfg_in.symbols_low = csr_data;
            end
            stirt_pkg::REG_SYMBOLS_HIGH: begin
               cfg_in.symbols_high = csr_data;
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.alphabet_size <= stirt_pkg::ALPHABET_SIZE_RESET;
         cfg_ff.symbols_low   <= stirt_pkg::SYMBOLS_LOW_RESET;
         cfg_ff.symbols_high  <= stirt_pkg::SYMBOLS_HIGH_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   stirt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   stirt_dp #(
      .VALUE_BITS (VALUE_BITS)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .req_value   (req_value),
      .cmd         (cmd),
      .sts         (sts),
      .rsp_symbol  (rsp_symbol),
      .rsp_last    (rsp_last),
      .rsp_invalid (rsp_invalid)
   );

`ifndef SYNTHESIS
   // an invalid-alphabet result stands alone with a zero symbol
   a_invalid_alone: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_invalid |-> rsp_last && (rsp_symbol == '0))
      else $error("invalid result not alone or symbol not zero");

   // a minus sign is never the final character of a number
   a_minus_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_invalid && (rsp_symbol == stirt_pkg::MINUS_CHAR) |-> !rsp_last)
      else $error("minus sign marked last");

   // an accepted item keeps the input closed in the following cycle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input open right after a transfer");
`endif

endmodule

FILE: hw/rtl/stirt_ctrl.sv
// sequencing state machine: accept, alphabet check, divide loop, emission
// depends on stirt_pkg; drives stirt_dp through cmd_type, watches sts_type
module stirt_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output stirt_pkg::cmd_type cmd,
   input  stirt_pkg::sts_type sts
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_CHECK,
      S_BAD,
      S_SIGN,
      S_DIVIDE,
      S_READ,
      S_EMIT
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;
   logic      load_any;

   // output register can take a new item
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.start = 1'b1;
               state_in  = S_CHECK;
            end
         end
         S_CHECK: begin
            if (!sts.alpha_ok) begin
               state_in = S_BAD;
            end else if (sts.negative) begin
               state_in = S_SIGN;
            end else begin
               state_in = S_DIVIDE;
            end
         end
         S_BAD: begin
            if (out_free) begin
               cmd.load_invalid = 1'b1;
               state_in         = S_IDLE;
            end
         end
         S_SIGN: begin
            if (out_free) begin
               cmd.load_sign = 1'b1;
               state_in      = S_DIVIDE;
            end
         end
         S_DIVIDE: begin
            cmd.div_step = 1'b1;
            if (sts.div_last && sts.quot_zero) begin
               state_in = S_READ;
            end
         end
         S_READ: begin
            cmd.mem_read = 1'b1;
            state_in     = S_EMIT;
         end
         S_EMIT: begin
            if (out_free) begin
               cmd.load_digit = 1'b1;
               if (sts.rd_zero) begin
                  state_in = S_IDLE;
               end else begin
                  cmd.rd_dec = 1'b1;
                  state_in   = S_READ;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // result valid flag
   assign load_any     = cmd.load_sign || cmd.load_digit || cmd.load_invalid;
   assign rsp_valid_in = load_any ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

FILE: hw/rtl/stirt_dp.sv
// datapath: magnitude, bit-serial radix divider, digit memory, output register
// depends on stirt_pkg; commanded by stirt_ctrl
module stirt_dp #(
   parameter int VALUE_BITS = stirt_pkg::VALUE_BITS_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  stirt_pkg::cfg_type               cfg,
   input  logic signed [VALUE_BITS-1:0]     req_value,
   input  stirt_pkg::cmd_type               cmd,
   output stirt_pkg::sts_type               sts,
   output logic [stirt_pkg::SYMBOL_W-1:0]   rsp_symbol,
   output logic                             rsp_last,
   output logic                             rsp_invalid
);

   localparam int IDX_W  = $clog2(VALUE_BITS);
   localparam int STEP_W = $clog2(VALUE_BITS);
   localparam int DW     = stirt_pkg::DIGIT_W;
   localparam int SW     = stirt_pkg::SYMBOL_W;

   logic [VALUE_BITS-1:0] mag_ff, mag_in;
   logic                  neg_ff, neg_in;
   logic [DW-1:0]         rem_ff, rem_in;
   logic [STEP_W-1:0]     step_ff, step_in;
   logic [IDX_W-1:0]      wr_idx_ff, wr_idx_in;
   logic [IDX_W-1:0]      rd_idx_ff, rd_idx_in;
   logic                  ok_ff, ok_in;
   logic [DW-1:0]         rd_data_ff;
   logic [DW-1:0]         digit_mem [VALUE_BITS];
   logic [SW-1:0]         symbol_ff, symbol_in;
   logic                  last_ff, last_in;
   logic                  invalid_ff, invalid_in;

   logic [VALUE_BITS-1:0] raw_mag;
   logic [DW:0]           r_shift;
   logic [DW:0]           r_sub;
   logic                  ge;
   logic [DW-1:0]         r_new;
   logic [VALUE_BITS-1:0] q_new;
   logic                  div_last;
   logic                  digit_done;
   logic [SW-1:0]         sym  [stirt_pkg::SLOTS];
   logic [stirt_pkg::SLOTS-1:0] in_use;
   logic                  bad_sym;

   // alphabet check over all symbol slots and pairs
   always_comb begin
      for (int i = 0; i < stirt_pkg::SLOTS; i++) begin
         sym[i]    = stirt_pkg::symbol_at(cfg.symbols_low, cfg.symbols_high, DW'(i));
         in_use[i] = (stirt_pkg::SIZE_W'(i) < cfg.alphabet_size);
      end
      bad_sym = 1'b0;
      for (int i = 0; i < stirt_pkg::SLOTS; i++) begin
         if (in_use[i] && (sym[i] == stirt_pkg::PLUS_CHAR
                           || sym[i] == stirt_pkg::MINUS_CHAR)) begin
            bad_sym = 1'b1;
         end
         for (int j = i + 1; j < stirt_pkg::SLOTS; j++) begin
            if (in_use[j] && sym[i] == sym[j]) begin
               bad_sym = 1'b1;
            end
         end
      end
      ok_in = !bad_sym && (cfg.alphabet_size >= stirt_pkg::SIZE_W'(2))
              && (cfg.alphabet_size <= stirt_pkg::SIZE_W'(stirt_pkg::MAX_SYMBOLS));
   end

   // magnitude of the input, exact for the most negative value
   assign raw_mag = req_value[VALUE_BITS-1] ? (~req_value + 1'b1) : req_value;

   // one restoring division step per cycle
   assign r_shift    = {rem_ff, mag_ff[VALUE_BITS-1]};
   assign ge         = (r_shift >= cfg.alphabet_size);
   assign r_sub      = r_shift - cfg.alphabet_size;
   assign r_new      = ge ? r_sub[DW-1:0] : r_shift[DW-1:0];
   assign q_new      = {mag_ff[VALUE_BITS-2:0], ge};
   assign div_last   = (step_ff == STEP_W'(VALUE_BITS - 1));
   assign digit_done = cmd.div_step && div_last;

   // divider and pointer next values
   always_comb begin
      mag_in    = mag_ff;
      neg_in    = neg_ff;
      rem_in    = rem_ff;
      step_in   = step_ff;
      wr_idx_in = wr_idx_ff;
      rd_idx_in = rd_idx_ff;
      if (cmd.start) begin
         mag_in    = raw_mag;
         neg_in    = req_value[VALUE_BITS-1];
         rem_in    = '0;
         step_in   = '0;
         wr_idx_in = '0;
      end else if (cmd.div_step) begin
         mag_in = q_new;
         if (div_last) begin
            rem_in    = '0;
            step_in   = '0;
            rd_idx_in = wr_idx_ff;
            wr_idx_in = wr_idx_ff + 1'b1;
         end else begin
            rem_in  = r_new;
            step_in = step_ff + 1'b1;
         end
      end else if (cmd.rd_dec) begin
         rd_idx_in = rd_idx_ff - 1'b1;
      end
   end

   // output register next values
   always_comb begin
      symbol_in  = symbol_ff;
      last_in    = last_ff;
      invalid_in = invalid_ff;
      if (cmd.load_invalid) begin
         symbol_in  = '0;
         last_in    = 1'b1;
         invalid_in = 1'b1;
      end else if (cmd.load_sign) begin
         symbol_in  = stirt_pkg::MINUS_CHAR;
         last_in    = 1'b0;
         invalid_in = 1'b0;
      end else if (cmd.load_digit) begin
         symbol_in  = stirt_pkg::symbol_at(cfg.symbols_low, cfg.symbols_high, rd_data_ff);
         last_in    = (rd_idx_ff == '0);
         invalid_in = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff   <= '0;
         wr_idx_ff <= '0;
         rd_idx_ff <= '0;
         neg_ff    <= 1'b0;
         ok_ff     <= 1'b1;
      end else begin
         step_ff   <= step_in;
         wr_idx_ff <= wr_idx_in;
         rd_idx_ff <= rd_idx_in;
         neg_ff    <= neg_in;
         ok_ff     <= ok_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      mag_ff     <= mag_in;
      rem_ff     <= rem_in;
      symbol_ff  <= symbol_in;
      last_ff    <= last_in;
      invalid_ff <= invalid_in;
   end

   // digit memory, one write and one registered read
   always_ff @(posedge clock) begin
      if (digit_done) begin
         digit_mem[wr_idx_ff] <= r_new;
      end
      if (cmd.mem_read) begin
         rd_data_ff <= digit_mem[rd_idx_ff];
      end
   end

   assign sts.alpha_ok  = ok_ff;
   assign sts.negative  = neg_ff;
   assign sts.div_last  = div_last;
   assign sts.quot_zero = (q_new == '0);
   assign sts.rd_zero   = (rd_idx_ff == '0);

   assign rsp_symbol  = symbol_ff;
   assign rsp_last    = last_ff;
   assign rsp_invalid = invalid_ff;

endmodule
